/* rtl/crc16_framed_command_deframer_core_macros.svh */
// ----------------------------------------------------------------------------
// CRC-16 framed command deframer - assertion macros
// Concurrent check shorthands; all sample on clk and are off during reset.
// ----------------------------------------------------------------------------
`ifndef CRC16_FRAMED_COMMAND_DEFRAMER_CORE_MACROS_SVH
`define CRC16_FRAMED_COMMAND_DEFRAMER_CORE_MACROS_SVH

// Condition must hold at every clock edge
`define CFD_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("deframer check failed");

// Same-cycle implication
`define CFD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deframer implication failed");

// Next-cycle implication
`define CFD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deframer next-cycle check failed");

`endif

/* rtl/cfd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-16 framed command deframer - package
// Shared constants, payload types and the byte-wide CRC-16/MODBUS update.
// ----------------------------------------------------------------------------
package cfd_pkg;

  localparam int NUM_SOURCES = 2;
  localparam int MAX_PAYLOAD = 255;

  // Frame byte positions within one channel's parser
  localparam logic [8:0] POS_HUNT    = 9'd0;
  localparam logic [8:0] POS_SYNC2   = 9'd1;
  localparam logic [8:0] POS_VERSION = 9'd2;
  localparam logic [8:0] POS_KIND    = 9'd3;
  localparam logic [8:0] POS_SET     = 9'd4;
  localparam logic [8:0] POS_ID      = 9'd5;
  localparam logic [8:0] POS_SEQ_LO  = 9'd6;
  localparam logic [8:0] POS_SEQ_HI  = 9'd7;
  localparam logic [8:0] POS_LEN     = 9'd8;
  localparam logic [8:0] HDR_END     = 9'd9;
  // last position reachable: header, full payload, two CRC bytes
  localparam logic [8:0] POS_LAST    = 9'(9 + MAX_PAYLOAD + 1);

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Register reset values
  localparam logic [7:0] SYNC_FIRST_RST  = 8'h5A;
  localparam logic [7:0] SYNC_SECOND_RST = 8'hA5;
  localparam logic [7:0] VERSION_RST     = 8'h01;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_SYNC_FIRST  = 2'd0,
    CFG_SYNC_SECOND = 2'd1,
    CFG_VERSION     = 2'd2
  } cfg_index_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD  = 2'd0,
    KIND_CRC_GOOD = 2'd1,
    KIND_CRC_BAD  = 2'd2
  } kind_t;

  typedef struct packed {
    logic       source;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    kind_t       kind;
    logic        out_source;
    logic [7:0]  payload_byte;
    logic [7:0]  payload_index;
    logic [7:0]  msg_kind;
    logic [7:0]  command_set;
    logic [7:0]  command_id;
    logic [15:0] sequence_res;
    logic [7:0]  payload_length;
  } out_item_t;

  typedef struct packed {
    logic [7:0] sync_first;
    logic [7:0] sync_second;
    logic [7:0] expected_version;
  } cfg_t;

  // Input register contents handed to the parser
  typedef struct packed {
    logic     valid;
    in_item_t item;
  } stage_t;

  // One byte through CRC-16/MODBUS, reflected, LSB first
  function automatic logic [15:0] crc16_update(input logic [15:0] crc,
                                               input logic [7:0]  b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

/* rtl/cfd_intf.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-16 framed command deframer - channel interfaces
// Valid/ready channels for received bytes, results and register writes.
// ----------------------------------------------------------------------------

// Received byte channel
interface cfd_in_if;
  import cfd_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// Result channel
interface cfd_out_if;
  import cfd_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// Register write channel
interface cfd_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/cfd_cfg_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-16 framed command deframer - configuration registers
// Sync bytes and expected version, written one register per request.
// ----------------------------------------------------------------------------
module cfd_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  logic [1:0]    wr_index,
  input  logic [7:0]    wr_data,
  output cfd_pkg::cfg_t cfg
);
  import cfd_pkg::*;

  cfg_t cfg_r;

  // Always able to take a write
  assign wr_ready = 1'b1;
  assign cfg      = cfg_r;

  // Register file; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_first       <= SYNC_FIRST_RST;
      cfg_r.sync_second      <= SYNC_SECOND_RST;
      cfg_r.expected_version <= VERSION_RST;
    end else if (wr_valid) begin
      unique case (cfg_index_t'(wr_index))
        CFG_SYNC_FIRST:  cfg_r.sync_first       <= wr_data;
        CFG_SYNC_SECOND: cfg_r.sync_second      <= wr_data;
        CFG_VERSION:     cfg_r.expected_version <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

/* rtl/cfd_in_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-16 framed command deframer - input register
// Captures one received byte; refills in the cycle the parser drains it.
// ----------------------------------------------------------------------------
module cfd_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  cfd_pkg::in_item_t in_item,
  input  logic              advance,
  output cfd_pkg::stage_t   stage
);
  import cfd_pkg::*;

  logic     valid_r;
  in_item_t item_r;

  assign in_ready    = !valid_r || advance;
  assign stage.valid = valid_r;
  assign stage.item  = item_r;

  // Valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  // Payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

endmodule

/* rtl/cfd_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-16 framed command deframer - per-channel parser
// Reads the channel state for the registered byte, updates it and loads
// the result register in the same cycle.
// ----------------------------------------------------------------------------
module cfd_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  cfd_pkg::cfg_t      cfg,
  input  cfd_pkg::stage_t    stage,
  output logic               advance,
  output logic               out_valid,
  input  logic               out_ready,
  output cfd_pkg::out_item_t out_data
);
  import cfd_pkg::*;

  `include "crc16_framed_command_deframer_core_macros.svh"

  // Per-channel state
  logic [8:0]  pos_r     [NUM_SOURCES];
  logic [23:0] ksi_r     [NUM_SOURCES];
  logic [15:0] seq_r     [NUM_SOURCES];
  logic [7:0]  len_r     [NUM_SOURCES];
  logic [15:0] crc_r     [NUM_SOURCES];
  logic [7:0]  crc_lo_r  [NUM_SOURCES];
  logic        ver_ok_r  [NUM_SOURCES];

  logic      out_valid_r;
  out_item_t out_data_r;

  logic        src;
  logic [7:0]  b;
  logic        src_ok;
  logic [8:0]  cur_pos;
  logic [7:0]  cur_len;
  logic [15:0] cur_crc;
  logic [15:0] crc_b;
  logic [8:0]  end_pos;

  logic [8:0]  pos_nxt;
  logic [23:0] ksi_nxt;
  logic [15:0] seq_nxt;
  logic [7:0]  len_nxt;
  logic [15:0] crc_nxt;
  logic [7:0]  crc_lo_nxt;
  logic        ver_ok_nxt;
  logic        clr;
  logic        emit;
  out_item_t   res;

  assign src     = stage.item.source;
  assign b       = stage.item.data_byte;
  assign src_ok  = (32'(src) < NUM_SOURCES);
  assign cur_pos = pos_r[src];
  assign cur_len = len_r[src];
  assign cur_crc = crc_r[src];
  assign crc_b   = crc16_update(cur_crc, b);
  assign end_pos = HDR_END + {1'b0, cur_len};

  // Stage moves when the result register is empty or being drained
  assign advance   = stage.valid && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Frame state machine for one byte
  always_comb begin
    pos_nxt    = cur_pos;
    ksi_nxt    = ksi_r[src];
    seq_nxt    = seq_r[src];
    len_nxt    = cur_len;
    crc_nxt    = cur_crc;
    crc_lo_nxt = crc_lo_r[src];
    ver_ok_nxt = ver_ok_r[src];
    clr        = 1'b0;
    emit       = 1'b0;
    res        = '0;
    res.kind       = KIND_PAYLOAD;
    res.out_source = src;

    priority if (cur_pos == POS_HUNT) begin
      if (b == cfg.sync_first) pos_nxt = POS_SYNC2;
    end else if (cur_pos == POS_SYNC2) begin
      if (b == cfg.sync_second) begin
        pos_nxt = POS_VERSION;
        crc_nxt = CRC_INIT;
      end else begin
        // broken sync; a repeated first sync byte restarts the frame
        clr     = 1'b1;
        pos_nxt = (b == cfg.sync_first) ? POS_SYNC2 : POS_HUNT;
      end
    end else if (cur_pos < HDR_END) begin
      crc_nxt = crc_b;
      pos_nxt = cur_pos + 9'd1;
      unique case (cur_pos)
        POS_VERSION: ver_ok_nxt      = (b == cfg.expected_version);
        POS_KIND:    ksi_nxt[23:16]  = b;
        POS_SET:     ksi_nxt[15:8]   = b;
        POS_ID:      ksi_nxt[7:0]    = b;
        POS_SEQ_LO:  seq_nxt[7:0]    = b;
        POS_SEQ_HI:  seq_nxt[15:8]   = b;
        default:     len_nxt         = b;
      endcase
      // header done: bad version or oversize length drops the frame
      if (cur_pos == POS_LEN &&
          (!ver_ok_r[src] || ({1'b0, b} > 9'(MAX_PAYLOAD)))) begin
        clr     = 1'b1;
        pos_nxt = POS_HUNT;
      end
    end else if (cur_pos < end_pos) begin
      // payload byte, passed straight through
      crc_nxt           = crc_b;
      pos_nxt           = cur_pos + 9'd1;
      emit              = 1'b1;
      res.payload_byte  = b;
      res.payload_index = 8'(cur_pos - HDR_END);
    end else if (cur_pos == end_pos) begin
      crc_lo_nxt = b;
      pos_nxt    = cur_pos + 9'd1;
    end else begin
      // second CRC byte closes the frame
      emit               = 1'b1;
      res.kind           = ({b, crc_lo_r[src]} == cur_crc) ? KIND_CRC_GOOD
                                                           : KIND_CRC_BAD;
      res.msg_kind       = ksi_r[src][23:16];
      res.command_set    = ksi_r[src][15:8];
      res.command_id     = ksi_r[src][7:0];
      res.sequence_res   = seq_r[src];
      res.payload_length = cur_len;
      clr                = 1'b1;
      pos_nxt            = POS_HUNT;
    end

    if (clr) begin
      ksi_nxt    = '0;
      seq_nxt    = '0;
      len_nxt    = '0;
      crc_nxt    = CRC_INIT;
      crc_lo_nxt = '0;
      ver_ok_nxt = 1'b0;
    end

    if (!src_ok) emit = 1'b0;
  end

  // Channel state write-back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NUM_SOURCES; s++) begin
        pos_r[s]    <= POS_HUNT;
        ksi_r[s]    <= '0;
        seq_r[s]    <= '0;
        len_r[s]    <= '0;
        crc_r[s]    <= CRC_INIT;
        crc_lo_r[s] <= '0;
        ver_ok_r[s] <= 1'b0;
      end
    end else if (advance && src_ok) begin
      pos_r[src]    <= pos_nxt;
      ksi_r[src]    <= ksi_nxt;
      seq_r[src]    <= seq_nxt;
      len_r[src]    <= len_nxt;
      crc_r[src]    <= crc_nxt;
      crc_lo_r[src] <= crc_lo_nxt;
      ver_ok_r[src] <= ver_ok_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= emit;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_data_r <= res;
    end
  end

  // Checks
  for (genvar g = 0; g < NUM_SOURCES; g++) begin : g_pos_chk
    `CFD_ASSERT(a_pos_range, pos_r[g] <= POS_LAST)
  end

  `CFD_ASSERT_IMP(a_payload_no_hdr,
                  out_valid_r && out_data_r.kind == KIND_PAYLOAD,
                  out_data_r.sequence_res == '0 && out_data_r.payload_length == '0 &&
                  out_data_r.msg_kind == '0)
  `CFD_ASSERT_IMP(a_end_no_payload,
                  out_valid_r && out_data_r.kind != KIND_PAYLOAD,
                  out_data_r.payload_byte == '0 && out_data_r.payload_index == '0)
  `CFD_ASSERT_IMP(a_stall_only_full, stage.valid && !advance,
                  out_valid_r && !out_ready)

endmodule

/* rtl/crc16_framed_command_deframer_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-16 framed command deframer - top level
// Per-channel frame parser with sync hunt, header capture and CRC check.
// ----------------------------------------------------------------------------
// Takes one received byte per clock from any channel, unless a result is
// waiting and not taken, and keeps a separate parser per channel. Each
// byte is first held in the input register; then its channel's state is
// read, advanced through a byte-wide CRC-16/MODBUS update and written back
// while the result register loads, and the result is offered from that
// register. Payload bytes are passed on as they arrive; the second CRC byte
// gives one frame-end result with the header fields and the CRC verdict, so
// the payload of a frame that ends with a bad CRC must be dropped downstream.
// Input ready falls only when a result is waiting and not taken. Reset puts
// every channel back to sync hunting at once; registers may be written at any
// time the block holds no byte in flight.
module crc16_framed_command_deframer_core (
  input logic              clk,
  input logic              rst_n,
  cfd_in_if.sink           in_ch,
  cfd_out_if.source        out_ch,
  cfd_cfg_if.sink          cfg_ch
);
  import cfd_pkg::*;

  cfg_t   cfg;
  stage_t stage;
  logic   advance;

  // Register file
  cfd_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (cfg_ch.valid),
    .wr_ready (cfg_ch.ready),
    .wr_index (cfg_ch.index),
    .wr_data  (cfg_ch.data),
    .cfg      (cfg)
  );

  // Input register
  cfd_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_item  (in_ch.data),
    .advance  (advance),
    .stage    (stage)
  );

  // Parser and result register
  cfd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .stage     (stage),
    .advance   (advance),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data)
  );

endmodule
